>>> rtl/cprf_pkg.sv
// Shared types and constants for the coalescing paint request FIFO.
package cprf_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int WINDOW_BITS_DEF = 16;
  localparam int COORD_BITS_DEF  = 16;
  localparam int OCC_BITS        = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MERGED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_OUT  = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the request on an input transfer
    logic exec;   // apply the captured request, load the result register
  } cmd_t;

endpackage

>>> rtl/cprf_if.sv
// Request and response channel interfaces of the coalescing paint request FIFO.
interface cprf_req_if #(
  parameter int WINDOW_BITS = cprf_pkg::WINDOW_BITS_DEF,
  parameter int COORD_BITS  = cprf_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic        [WINDOW_BITS-1:0] window_id;
  logic signed [COORD_BITS-1:0]  rect_left;
  logic signed [COORD_BITS-1:0]  rect_top;
  logic signed [COORD_BITS-1:0]  rect_right;
  logic signed [COORD_BITS-1:0]  rect_bottom;

  modport source (output valid, op, window_id, rect_left, rect_top, rect_right, rect_bottom,
                  input ready);
  modport sink   (input valid, op, window_id, rect_left, rect_top, rect_right, rect_bottom,
                  output ready);
endinterface

interface cprf_rsp_if #(
  parameter int WINDOW_BITS = cprf_pkg::WINDOW_BITS_DEF,
  parameter int COORD_BITS  = cprf_pkg::COORD_BITS_DEF,
  parameter int OCC_BITS    = cprf_pkg::OCC_BITS
);
  logic                          valid;
  logic                          ready;
  logic        [1:0]             status;
  logic                          notify;
  logic        [WINDOW_BITS-1:0] out_window;
  logic signed [COORD_BITS-1:0]  out_left;
  logic signed [COORD_BITS-1:0]  out_top;
  logic signed [COORD_BITS-1:0]  out_right;
  logic signed [COORD_BITS-1:0]  out_bottom;
  logic        [OCC_BITS-1:0]    occupancy;

  modport source (output valid, status, notify, out_window, out_left, out_top, out_right,
                  out_bottom, occupancy, input ready);
  modport sink   (input valid, status, notify, out_window, out_left, out_top, out_right,
                  out_bottom, occupancy, output ready);
endinterface

>>> rtl/cprf_ctrl.sv
// Sequencing state machine: accept, execute, hold result until transfer.
module cprf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cprf_pkg::cmd_t cmd
);
  import cprf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/cprf_dpath.sv
// Entry store, ring pointers, merge logic and result register.
module cprf_dpath #(
  parameter int DEPTH       = cprf_pkg::DEPTH_DEF,
  parameter int WINDOW_BITS = cprf_pkg::WINDOW_BITS_DEF,
  parameter int COORD_BITS  = cprf_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cprf_pkg::cmd_t                  cmd,
  input  logic                            op,
  input  logic        [WINDOW_BITS-1:0]   window_id,
  input  logic signed [COORD_BITS-1:0]    rect_left,
  input  logic signed [COORD_BITS-1:0]    rect_top,
  input  logic signed [COORD_BITS-1:0]    rect_right,
  input  logic signed [COORD_BITS-1:0]    rect_bottom,
  output logic        [1:0]               status,
  output logic                            notify,
  output logic        [WINDOW_BITS-1:0]   out_window,
  output logic signed [COORD_BITS-1:0]    out_left,
  output logic signed [COORD_BITS-1:0]    out_top,
  output logic signed [COORD_BITS-1:0]    out_right,
  output logic signed [COORD_BITS-1:0]    out_bottom,
  output logic        [cprf_pkg::OCC_BITS-1:0] occupancy
);
  import cprf_pkg::*;

  localparam int PTR_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int ENTRY_BITS = WINDOW_BITS + 4 * COORD_BITS;
  localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

  // entry layout: window, left, top, right, bottom
  logic [ENTRY_BITS-1:0] mem [DEPTH];
  logic [ENTRY_BITS-1:0] rd_head;
  logic [ENTRY_BITS-1:0] rd_newest;

  logic [PTR_BITS-1:0] head_index;
  logic [PTR_BITS-1:0] tail_index;
  logic [PTR_BITS-1:0] newest_index;
  logic [CNT_BITS-1:0] entry_count;

  // captured request
  logic                          req_op;
  logic        [WINDOW_BITS-1:0] req_win;
  logic signed [COORD_BITS-1:0]  req_l, req_t, req_r, req_b;

  logic        [WINDOW_BITS-1:0] nw_win;
  logic signed [COORD_BITS-1:0]  nw_l, nw_t, nw_r, nw_b;
  logic signed [COORD_BITS-1:0]  mg_l, mg_t, mg_r, mg_b;

  logic                is_empty, is_full, do_merge, do_append, do_pop;
  logic                wr_en;
  logic [PTR_BITS-1:0] wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;
  status_t             st_next;
  logic [CNT_BITS-1:0] count_next;
  logic [CNT_BITS+OCC_BITS-1:0] occ_wide;

  assign newest_index = (tail_index == '0) ? LAST_SLOT : tail_index - 1'b1;

  // two registered read ports: oldest and newest entry
  always_ff @(posedge clk) begin
    rd_head   <= mem[head_index];
    rd_newest <= mem[newest_index];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op  <= op;
      req_win <= window_id;
      req_l   <= rect_left;
      req_t   <= rect_top;
      req_r   <= rect_right;
      req_b   <= rect_bottom;
    end
  end

  assign {nw_win, nw_l, nw_t, nw_r, nw_b} = rd_newest;

  assign mg_l = (req_l < nw_l) ? req_l : nw_l;
  assign mg_t = (req_t < nw_t) ? req_t : nw_t;
  assign mg_r = (req_r > nw_r) ? req_r : nw_r;
  assign mg_b = (req_b > nw_b) ? req_b : nw_b;

  assign is_empty  = (entry_count == '0);
  assign is_full   = (entry_count == FULL_CNT);
  assign do_merge  = (req_op == OP_ENQ) && !is_empty && (nw_win == req_win);
  assign do_append = (req_op == OP_ENQ) && !do_merge && !is_full;
  assign do_pop    = (req_op == OP_DEQ) && !is_empty;

  always_comb begin
    wr_en      = cmd.exec && (do_merge || do_append);
    wr_addr    = do_merge ? newest_index : tail_index;
    wr_data    = do_merge ? {nw_win, mg_l, mg_t, mg_r, mg_b}
                          : {req_win, req_l, req_t, req_r, req_b};
    count_next = entry_count;
    if (do_append) count_next = entry_count + 1'b1;
    else if (do_pop) count_next = entry_count - 1'b1;
    if (req_op == OP_DEQ) st_next = is_empty ? ST_EMPTY : ST_OK;
    else if (do_merge)    st_next = ST_MERGED;
    else if (is_full)     st_next = ST_FULL;
    else                  st_next = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      tail_index  <= '0;
      entry_count <= '0;
    end else if (cmd.exec) begin
      entry_count <= count_next;
      if (do_append) tail_index <= (tail_index == LAST_SLOT) ? '0 : tail_index + 1'b1;
      if (do_pop)    head_index <= (head_index == LAST_SLOT) ? '0 : head_index + 1'b1;
    end
  end

  // count is wrapped to the occupancy field width
  assign occ_wide = {{OCC_BITS{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status    <= st_next;
      notify    <= do_append;
      occupancy <= occ_wide[OCC_BITS-1:0];
      if (do_pop) begin
        {out_window, out_left, out_top, out_right, out_bottom} <= rd_head;
      end else begin
        {out_window, out_left, out_top, out_right, out_bottom} <= '0;
      end
    end
  end

endmodule

>>> rtl/coalescing_paint_request_fifo_core.sv
// Coalescing paint request FIFO: one request accepted, one result per request.
// The request is captured on its transfer; the execute state loads the result
// register, and the result is offered in the output state until it is taken.
// Requests are handled one at a time (accept, execute, result transfer) by the
// sequencer; no new request is accepted before the result transfer, so result stalls hold it off.
// Reset (rst, synchronous): FIFO emptied, head/tail cleared, controller idle;
// entry store contents are not cleared.
module coalescing_paint_request_fifo_core #(
  parameter int DEPTH       = cprf_pkg::DEPTH_DEF,
  parameter int WINDOW_BITS = cprf_pkg::WINDOW_BITS_DEF,
  parameter int COORD_BITS  = cprf_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cprf_req_if.sink   req,
  cprf_rsp_if.source rsp
);
  import cprf_pkg::*;

  cmd_t cmd;

  cprf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  cprf_dpath #(
    .DEPTH       (DEPTH),
    .WINDOW_BITS (WINDOW_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (req.op),
    .window_id   (req.window_id),
    .rect_left   (req.rect_left),
    .rect_top    (req.rect_top),
    .rect_right  (req.rect_right),
    .rect_bottom (req.rect_bottom),
    .status      (rsp.status),
    .notify      (rsp.notify),
    .out_window  (rsp.out_window),
    .out_left    (rsp.out_left),
    .out_top     (rsp.out_top),
    .out_right   (rsp.out_right),
    .out_bottom  (rsp.out_bottom),
    .occupancy   (rsp.occupancy)
  );

endmodule
